### hw/rtl/jsfe_pkg.sv
// Shared types, codes and constants of the joint stress and fracture evaluator.
// Used by jsfe_mul, jsfe_div and joint_stress_fracture_evaluator_top.
`default_nettype none
package jsfe_pkg;

    localparam int MAX_JOINTS_DEF = 1024;
    localparam int WIDE_W         = 128;

    // request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EVAL = 2'd1;
    localparam logic [1:0] REQ_STEP = 2'd2;

    localparam logic [39:0]  AREA_FLOOR   = 40'd10000;
    localparam logic [67:0]  SX_FLOOR     = 68'd153600000000;
    localparam logic [127:0] K_NORMAL     = 128'd1000000000000000000;
    localparam logic [127:0] K_BEND_A     = 128'd6000000000000;
    localparam logic [127:0] K_BEND_B     = 128'd1000000000000;
    localparam logic [127:0] K_USEC       = 128'd1000000;
    localparam logic [15:0]  DMG_RATE_RST = 16'd52429;
    localparam logic [10:0]  CNT_MAX      = 11'd2047;
    localparam logic [47:0]  SAT48        = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0]  SAT32        = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_NUM1,
        ST_MUL_DEN1,
        ST_DIV_NORMAL,
        ST_SQRT,
        ST_MUL_SX,
        ST_MUL_ANG1,
        ST_MUL_ANG2,
        ST_MUL_DEN2,
        ST_DIV_BEND,
        ST_DIV_STRAIN,
        ST_MUL_INC1,
        ST_MUL_INC2,
        ST_MUL_YD,
        ST_DIV_INC,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [39:0] area;
        logic [47:0] stiff;
        logic [47:0] yld;
        logic [47:0] tens;
        logic [31:0] dmg;
        logic        ymark;
        logic        bmark;
    } t_entry;

endpackage
`default_nettype wire

### hw/rtl/jsfe_mul.sv
// Sequential 128 x 128 multiplier (low 128 bits kept), one 32 x 32 partial product a cycle.
// Depends on jsfe_pkg.
`default_nettype none
module jsfe_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [jsfe_pkg::WIDE_W-1:0] i_a,
    input  wire logic [jsfe_pkg::WIDE_W-1:0] i_b,
    output logic                             o_done,
    output logic [jsfe_pkg::WIDE_W-1:0]      o_prod
);
    localparam int CW = 32;

    logic [jsfe_pkg::WIDE_W-1:0] r_a, r_b, r_acc;
    logic [3:0]                  r_cnt;
    logic                        r_busy, r_last, r_pv, r_done;
    logic [2*CW-1:0]             r_p;
    logic [2:0]                  r_sh;

    logic [1:0]      ai, bj;
    logic [CW-1:0]   a_ch, b_ch;
    logic [2*CW-1:0] pp;
    logic [255:0]    ext;

    // select the chunk pair and form its product
    assign ai   = r_cnt[3:2];
    assign bj   = r_cnt[1:0];
    assign a_ch = r_a[ai*CW +: CW];
    assign b_ch = r_b[bj*CW +: CW];
    assign pp   = a_ch * b_ch;
    assign ext  = {192'd0, r_p} << {r_sh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_last <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= 4'd0;
                r_acc  <= '0;
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_last <= 1'b0;
            end else begin
                // issue one partial product
                if (r_busy) begin
                    r_p   <= pp;
                    r_sh  <= {1'b0, ai} + {1'b0, bj};
                    r_pv  <= 1'b1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'hF) begin
                        r_busy <= 1'b0;
                        r_last <= 1'b1;
                    end
                end else begin
                    r_pv   <= 1'b0;
                    r_last <= 1'b0;
                end
                // accumulate the registered product
                if (r_pv) begin
                    r_acc <= r_acc + ext[jsfe_pkg::WIDE_W-1:0];
                end
                if (r_last) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

### hw/rtl/jsfe_div.sv
// Restoring divider, 128-bit numerator and denominator, one quotient bit a cycle.
// Depends on jsfe_pkg.
`default_nettype none
module jsfe_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [jsfe_pkg::WIDE_W-1:0] i_num,
    input  wire logic [jsfe_pkg::WIDE_W-1:0] i_den,
    output logic                             o_done,
    output logic [jsfe_pkg::WIDE_W-1:0]      o_quot
);
    localparam int W     = jsfe_pkg::WIDE_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]       r_q, r_rem, r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy, r_done;

    logic [W:0] rem_sh, rem_sub;
    logic       take;

    // trial subtract of the shifted remainder
    assign rem_sh  = {r_rem, r_q[W-1]};
    assign take    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= take ? rem_sub[W-1:0] : rem_sh[W-1:0];
                r_q   <= {r_q[W-2:0], take};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

### hw/rtl/joint_stress_fracture_evaluator_top.sv
// Joint stress and fracture evaluator: joint table in one memory, shared multiplier and divider.
// Load, begin-step and unknown transactions go straight to the output state, a skipped evaluate
// by way of the decide state; a full evaluate runs the multiply, divide and square-root steps,
// with the damage steps added when the joint yields. One transaction at a time, the next accepted
// once the result is registered. The steps use the restoring divider, chunked multiplier and square root.
// Synchronous reset, then a clearing pass over all MAX_JOINTS table entries with input stalled.
`default_nettype none
module joint_stress_fracture_evaluator_top #(
    parameter int MAX_JOINTS = jsfe_pkg::MAX_JOINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [9:0]  i_joint_index,
    input  wire logic [39:0] i_linear_impulse,
    input  wire logic [39:0] i_angular_impulse,
    input  wire logic [19:0] i_time_step,
    input  wire logic [39:0] i_contact_area,
    input  wire logic [47:0] i_stiffness,
    input  wire logic [47:0] i_yield_limit,
    input  wire logic [47:0] i_tensile_limit,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [47:0]      o_stress_pa,
    output logic [31:0]      o_strain_frac,
    output logic             o_is_yielded,
    output logic             o_is_broken,
    output logic             o_disable_joint,
    output logic [10:0]      o_yielded_total,
    output logic [10:0]      o_broken_total,
    output logic [47:0]      o_peak_stress,
    output logic [31:0]      o_peak_strain
);
    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int W  = jsfe_pkg::WIDE_W;

    jsfe_pkg::t_state r_state, n_state;
    jsfe_pkg::t_entry r_joint_mem [MAX_JOINTS];
    jsfe_pkg::t_entry r_rd, mem_wdata;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    logic          r_go;
    logic [AW-1:0] r_clr_cnt, r_addr;
    logic [15:0]   r_dmg_rate;
    logic [39:0]   r_lin, r_ang;
    logic [19:0]   r_t;
    logic [W-1:0]  r_num, r_den;
    logic [47:0]   r_normal, r_stress;
    logic [67:0]   r_sx;
    logic [27:0]   r_root;
    logic [63:0]   r_sq_v, r_sq_res, r_sq_bit;
    logic [31:0]   r_strain, r_inc;
    logic [10:0]   r_yc, r_bc;
    logic [47:0]   r_ps;
    logic [31:0]   r_pst;
    logic [47:0]   r_res_stress;
    logic [31:0]   r_res_strain;
    logic          r_res_yl, r_res_br, r_res_dis;
    logic          r_out_valid;

    logic          mul_start, mul_done, div_start, div_done;
    logic [W-1:0]  mul_a, mul_b, mul_prod, div_num, div_den, div_q;

    logic          in_accept, in_ok;
    logic [16:0]   idx17;
    logic [AW-1:0] in_addr;
    logic [39:0]   a_fl;
    logic [47:0]   k_fl, yp;
    logic          is_yl, brk;
    logic [32:0]   dmg_sum;
    logic [31:0]   dmg_new;
    logic [47:0]   q_sat48;
    logic [31:0]   q_sat32;
    logic [48:0]   stress_sum;
    logic [63:0]   sq_try;

    // input handshake and index check
    assign in_accept  = i_in_valid && (r_state == jsfe_pkg::ST_IDLE);
    assign o_in_stall = (r_state != jsfe_pkg::ST_IDLE);
    assign idx17      = {7'd0, i_joint_index};
    assign in_ok      = idx17 < 17'(MAX_JOINTS);
    assign in_addr    = idx17[AW-1:0];

    // entry operands with their floors
    assign a_fl = (r_rd.area < jsfe_pkg::AREA_FLOOR) ? jsfe_pkg::AREA_FLOOR : r_rd.area;
    assign k_fl = (r_rd.stiff == 48'd0) ? 48'd1 : r_rd.stiff;
    assign yp   = (r_rd.yld == 48'd0) ? 48'd1 : r_rd.yld;

    // damage and breakage decision
    assign is_yl   = r_stress > r_rd.yld;
    assign dmg_sum = {1'b0, r_rd.dmg} + {1'b0, r_inc};
    assign dmg_new = is_yl ? (dmg_sum[32] ? jsfe_pkg::SAT32 : dmg_sum[31:0]) : r_rd.dmg;
    assign brk     = (r_stress >= r_rd.tens) || (dmg_new[31:24] != 8'd0);

    // quotient saturation and stress sum
    assign q_sat48    = (div_q[W-1:48] != '0) ? jsfe_pkg::SAT48 : div_q[47:0];
    assign q_sat32    = (div_q[W-1:32] != '0) ? jsfe_pkg::SAT32 : div_q[31:0];
    assign stress_sum = {1'b0, r_normal} + {1'b0, q_sat48};
    assign sq_try     = r_sq_res + r_sq_bit;

    jsfe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    jsfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsfe_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and arithmetic unit control
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = r_num;
        div_den   = r_den;
        unique case (r_state)
            jsfe_pkg::ST_CLEAR: begin
                if (r_clr_cnt == AW'(MAX_JOINTS - 1)) n_state = jsfe_pkg::ST_IDLE;
            end
            jsfe_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_req_type == jsfe_pkg::REQ_EVAL && in_ok) n_state = jsfe_pkg::ST_DECIDE;
                    else n_state = jsfe_pkg::ST_OUT;
                end
            end
            jsfe_pkg::ST_DECIDE: begin
                if (!r_rd.valid || r_t == 20'd0 || r_rd.bmark) n_state = jsfe_pkg::ST_OUT;
                else n_state = jsfe_pkg::ST_MUL_NUM1;
            end
            jsfe_pkg::ST_MUL_NUM1: begin
                mul_a     = W'(r_lin);
                mul_b     = jsfe_pkg::K_NORMAL;
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_MUL_DEN1;
            end
            jsfe_pkg::ST_MUL_DEN1: begin
                mul_a     = W'(r_t);
                mul_b     = W'(a_fl);
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_DIV_NORMAL;
            end
            jsfe_pkg::ST_DIV_NORMAL: begin
                div_start = !r_go;
                if (r_go && div_done) n_state = jsfe_pkg::ST_SQRT;
            end
            jsfe_pkg::ST_SQRT: begin
                if (r_go && r_sq_bit == 64'd0) n_state = jsfe_pkg::ST_MUL_SX;
            end
            jsfe_pkg::ST_MUL_SX: begin
                mul_a     = W'(a_fl);
                mul_b     = W'(r_root);
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_MUL_ANG1;
            end
            jsfe_pkg::ST_MUL_ANG1: begin
                mul_a     = W'(r_ang);
                mul_b     = jsfe_pkg::K_BEND_A;
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_MUL_ANG2;
            end
            jsfe_pkg::ST_MUL_ANG2: begin
                mul_a     = r_num;
                mul_b     = jsfe_pkg::K_BEND_B;
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_MUL_DEN2;
            end
            jsfe_pkg::ST_MUL_DEN2: begin
                mul_a     = W'(r_sx);
                mul_b     = W'(r_t);
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_DIV_BEND;
            end
            jsfe_pkg::ST_DIV_BEND: begin
                div_start = !r_go;
                if (r_go && div_done) n_state = jsfe_pkg::ST_DIV_STRAIN;
            end
            jsfe_pkg::ST_DIV_STRAIN: begin
                div_num   = W'({r_stress, 32'd0});
                div_den   = W'(k_fl);
                div_start = !r_go;
                if (r_go && div_done) begin
                    n_state = is_yl ? jsfe_pkg::ST_MUL_INC1 : jsfe_pkg::ST_WRITE;
                end
            end
            jsfe_pkg::ST_MUL_INC1: begin
                mul_a     = W'(r_stress - yp);
                mul_b     = W'(r_t);
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_MUL_INC2;
            end
            jsfe_pkg::ST_MUL_INC2: begin
                mul_a     = r_num;
                mul_b     = W'(r_dmg_rate);
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_MUL_YD;
            end
            jsfe_pkg::ST_MUL_YD: begin
                mul_a     = W'(yp);
                mul_b     = jsfe_pkg::K_USEC;
                mul_start = !r_go;
                if (r_go && mul_done) n_state = jsfe_pkg::ST_DIV_INC;
            end
            jsfe_pkg::ST_DIV_INC: begin
                div_start = !r_go;
                if (r_go && div_done) n_state = jsfe_pkg::ST_WRITE;
            end
            jsfe_pkg::ST_WRITE: begin
                n_state = jsfe_pkg::ST_OUT;
            end
            jsfe_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) n_state = jsfe_pkg::ST_IDLE;
            end
            default: begin
                n_state = jsfe_pkg::ST_IDLE;
            end
        endcase
    end

    // table write port: clearing pass, load, write back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rd;
        if (r_state == jsfe_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wdata = '0;
        end else if (in_accept && i_req_type == jsfe_pkg::REQ_LOAD && in_ok) begin
            mem_we          = 1'b1;
            mem_waddr       = in_addr;
            mem_wdata.valid = 1'b1;
            mem_wdata.area  = i_contact_area;
            mem_wdata.stiff = i_stiffness;
            mem_wdata.yld   = i_yield_limit;
            mem_wdata.tens  = i_tensile_limit;
            mem_wdata.dmg   = 32'd0;
            mem_wdata.ymark = 1'b0;
            mem_wdata.bmark = 1'b0;
        end else if (r_state == jsfe_pkg::ST_WRITE) begin
            mem_we          = 1'b1;
            mem_wdata.dmg   = dmg_new;
            mem_wdata.ymark = r_rd.ymark | is_yl;
            mem_wdata.bmark = brk;
        end
    end

    // joint table, read on accept
    always_ff @(posedge i_clk) begin
        if (mem_we) r_joint_mem[mem_waddr] <= mem_wdata;
        if (in_accept) r_rd <= r_joint_mem[in_addr];
    end

    // datapath and step state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go        <= 1'b0;
            r_clr_cnt   <= '0;
            r_dmg_rate  <= jsfe_pkg::DMG_RATE_RST;
            r_yc        <= 11'd0;
            r_bc        <= 11'd0;
            r_ps        <= 48'd0;
            r_pst       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_dmg_rate <= i_cfg_wdata;
            if (r_out_valid && !i_out_stall && r_state != jsfe_pkg::ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (mul_start || div_start) r_go <= 1'b1;

            unique case (r_state)
                jsfe_pkg::ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                end
                jsfe_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_addr       <= in_addr;
                        r_lin        <= i_linear_impulse;
                        r_ang        <= i_angular_impulse;
                        r_t          <= i_time_step;
                        r_res_stress <= 48'd0;
                        r_res_strain <= 32'd0;
                        r_res_yl     <= 1'b0;
                        r_res_br     <= 1'b0;
                        r_res_dis    <= 1'b0;
                        if (i_req_type == jsfe_pkg::REQ_STEP) begin
                            r_yc  <= 11'd0;
                            r_bc  <= 11'd0;
                            r_ps  <= 48'd0;
                            r_pst <= 32'd0;
                        end
                    end
                end
                jsfe_pkg::ST_DECIDE: begin
                    if (r_rd.valid && r_t == 20'd0) begin
                        r_res_br <= r_rd.bmark;
                    end else if (r_rd.valid && r_rd.bmark) begin
                        r_res_br <= 1'b1;
                        if (r_bc != jsfe_pkg::CNT_MAX) r_bc <= r_bc + 11'd1;
                    end
                end
                jsfe_pkg::ST_MUL_NUM1, jsfe_pkg::ST_MUL_ANG1, jsfe_pkg::ST_MUL_ANG2,
                jsfe_pkg::ST_MUL_INC1: begin
                    if (r_go && mul_done) begin
                        r_go  <= 1'b0;
                        r_num <= mul_prod;
                    end
                end
                jsfe_pkg::ST_MUL_INC2: begin
                    if (r_go && mul_done) begin
                        r_go  <= 1'b0;
                        r_num <= mul_prod << 8;
                    end
                end
                jsfe_pkg::ST_MUL_DEN1: begin
                    if (r_go && mul_done) begin
                        r_go  <= 1'b0;
                        r_den <= mul_prod << 16;
                    end
                end
                jsfe_pkg::ST_MUL_DEN2: begin
                    if (r_go && mul_done) begin
                        r_go  <= 1'b0;
                        r_den <= mul_prod << 8;
                    end
                end
                jsfe_pkg::ST_MUL_YD: begin
                    if (r_go && mul_done) begin
                        r_go  <= 1'b0;
                        r_den <= mul_prod;
                    end
                end
                jsfe_pkg::ST_MUL_SX: begin
                    if (r_go && mul_done) begin
                        r_go <= 1'b0;
                        r_sx <= (mul_prod[67:0] < jsfe_pkg::SX_FLOOR) ? jsfe_pkg::SX_FLOOR
                                                                      : mul_prod[67:0];
                    end
                end
                jsfe_pkg::ST_DIV_NORMAL: begin
                    if (r_go && div_done) begin
                        r_go     <= 1'b0;
                        r_normal <= q_sat48;
                    end
                end
                jsfe_pkg::ST_DIV_BEND: begin
                    if (r_go && div_done) begin
                        r_go     <= 1'b0;
                        r_stress <= stress_sum[48] ? jsfe_pkg::SAT48 : stress_sum[47:0];
                    end
                end
                jsfe_pkg::ST_DIV_STRAIN: begin
                    if (r_go && div_done) begin
                        r_go     <= 1'b0;
                        r_strain <= q_sat32;
                    end
                end
                jsfe_pkg::ST_DIV_INC: begin
                    if (r_go && div_done) begin
                        r_go  <= 1'b0;
                        r_inc <= q_sat32;
                    end
                end
                jsfe_pkg::ST_SQRT: begin
                    // one result bit per step, bit walks down by two
                    if (!r_go) begin
                        r_go     <= 1'b1;
                        r_sq_v   <= {8'd0, a_fl, 16'd0};
                        r_sq_res <= 64'd0;
                        r_sq_bit <= 64'h4000_0000_0000_0000;
                    end else if (r_sq_bit != 64'd0) begin
                        if (r_sq_v >= sq_try) begin
                            r_sq_v   <= r_sq_v - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end else begin
                        r_go   <= 1'b0;
                        r_root <= r_sq_res[27:0];
                    end
                end
                jsfe_pkg::ST_WRITE: begin
                    r_res_stress <= r_stress;
                    r_res_strain <= r_strain;
                    r_res_yl     <= is_yl;
                    r_res_br     <= brk;
                    r_res_dis    <= brk;
                    if (r_stress > r_ps) r_ps <= r_stress;
                    if (r_strain > r_pst) r_pst <= r_strain;
                    if (is_yl && r_yc != jsfe_pkg::CNT_MAX) r_yc <= r_yc + 11'd1;
                    if (brk && r_bc != jsfe_pkg::CNT_MAX) r_bc <= r_bc + 11'd1;
                end
                jsfe_pkg::ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid     <= 1'b1;
                        o_stress_pa     <= r_res_stress;
                        o_strain_frac   <= r_res_strain;
                        o_is_yielded    <= r_res_yl;
                        o_is_broken     <= r_res_br;
                        o_disable_joint <= r_res_dis;
                        o_yielded_total <= r_yc;
                        o_broken_total  <= r_bc;
                        o_peak_stress   <= r_ps;
                        o_peak_strain   <= r_pst;
                    end
                end
                default: begin
                    r_go <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // a result appears only from the output state
    a_out_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == jsfe_pkg::ST_OUT)
        else $error("result valid rose outside the output state");

    // in idle the table is written only by an accepted load
    a_idle_write_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == jsfe_pkg::ST_IDLE)
            |-> (in_accept && i_req_type == jsfe_pkg::REQ_LOAD))
        else $error("table written in idle without a load transaction");

    // the step peak only grows until a begin-step transaction
    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(in_accept && i_req_type == jsfe_pkg::REQ_STEP))
            |-> r_ps >= $past(r_ps))
        else $error("peak stress fell without a begin-step transaction");

endmodule
`default_nettype wire

### tb/sv/joint_stress_fracture_evaluator_top_test.sv
// Testbench for joint_stress_fracture_evaluator_top: directed and random joint transactions,
// each result checked against a cycle-free model of the stress, strain and damage arithmetic.
// Depends on jsfe_pkg and the evaluator RTL.
`default_nettype none
module joint_stress_fracture_evaluator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 6000000;
    localparam int         LONG_HOLD   = 3000;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    typedef struct {
        logic [1:0]  req;
        logic [9:0]  idx;
        logic [39:0] lin;
        logic [39:0] ang;
        logic [19:0] dt;
        logic [39:0] area;
        logic [47:0] stiff;
        logic [47:0] yld;
        logic [47:0] tens;
    } t_joint_req;

    typedef struct {
        logic [47:0] stress;
        logic [31:0] strain;
        logic        yl;
        logic        br;
        logic        dis;
        logic [10:0] ytot;
        logic [10:0] btot;
        logic [47:0] pks;
        logic [31:0] pkn;
    } t_joint_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [9:0]  i_joint_index = '0;
    logic [39:0] i_linear_impulse = '0;
    logic [39:0] i_angular_impulse = '0;
    logic [19:0] i_time_step = '0;
    logic [39:0] i_contact_area = '0;
    logic [47:0] i_stiffness = '0;
    logic [47:0] i_yield_limit = '0;
    logic [47:0] i_tensile_limit = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [47:0] o_stress_pa;
    logic [31:0] o_strain_frac;
    logic        o_is_yielded;
    logic        o_is_broken;
    logic        o_disable_joint;
    logic [10:0] o_yielded_total;
    logic [10:0] o_broken_total;
    logic [47:0] o_peak_stress;
    logic [31:0] o_peak_strain;

    joint_stress_fracture_evaluator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_joint_index(i_joint_index),
        .i_linear_impulse(i_linear_impulse), .i_angular_impulse(i_angular_impulse),
        .i_time_step(i_time_step), .i_contact_area(i_contact_area),
        .i_stiffness(i_stiffness), .i_yield_limit(i_yield_limit),
        .i_tensile_limit(i_tensile_limit),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_stress_pa(o_stress_pa), .o_strain_frac(o_strain_frac),
        .o_is_yielded(o_is_yielded), .o_is_broken(o_is_broken),
        .o_disable_joint(o_disable_joint),
        .o_yielded_total(o_yielded_total), .o_broken_total(o_broken_total),
        .o_peak_stress(o_peak_stress), .o_peak_strain(o_peak_strain)
    );

    // model copy of the joint table, step state and damage rate
    logic        tab_valid [jsfe_pkg::MAX_JOINTS_DEF];
    logic [39:0] tab_area  [jsfe_pkg::MAX_JOINTS_DEF];
    logic [47:0] tab_stiff [jsfe_pkg::MAX_JOINTS_DEF];
    logic [47:0] tab_yld   [jsfe_pkg::MAX_JOINTS_DEF];
    logic [47:0] tab_tens  [jsfe_pkg::MAX_JOINTS_DEF];
    logic [31:0] tab_dmg   [jsfe_pkg::MAX_JOINTS_DEF];
    logic        tab_ymark [jsfe_pkg::MAX_JOINTS_DEF];
    logic        tab_bmark [jsfe_pkg::MAX_JOINTS_DEF];
    logic [10:0] step_yields;
    logic [10:0] step_breaks;
    logic [47:0] step_max_stress;
    logic [31:0] step_max_strain;
    logic [15:0] model_rate;

    t_joint_res pending_results[$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 0;
    bit  long_hold = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [127:0] div_capped(logic [127:0] num, logic [127:0] den,
                                                logic [127:0] cap);
        logic [127:0] q;
        if (den == 0) return cap;
        q = num / den;
        return (q > cap) ? cap : q;
    endfunction

    // Compute the result of one transaction and advance the model state.
    function automatic t_joint_res evaluate_joint(t_joint_req r);
        t_joint_res   e;
        logic [127:0] a, k, yp, sx, v, bitv, root, stress, strain, inc, d;
        logic [127:0] normal, bending;
        e = '{default: '0};
        if (r.req == jsfe_pkg::REQ_STEP) begin
            step_yields = '0;
            step_breaks = '0;
            step_max_stress = '0;
            step_max_strain = '0;
        end else if (r.req == jsfe_pkg::REQ_LOAD) begin
            tab_valid[r.idx] = 1'b1;
            tab_area[r.idx]  = r.area;
            tab_stiff[r.idx] = r.stiff;
            tab_yld[r.idx]   = r.yld;
            tab_tens[r.idx]  = r.tens;
            tab_dmg[r.idx]   = '0;
            tab_ymark[r.idx] = 1'b0;
            tab_bmark[r.idx] = 1'b0;
        end else if (r.req == jsfe_pkg::REQ_EVAL && tab_valid[r.idx]) begin
            if (r.dt == 0) begin
                e.br = tab_bmark[r.idx];
            end else if (tab_bmark[r.idx]) begin
                e.br = 1'b1;
                if (step_breaks < jsfe_pkg::CNT_MAX) step_breaks++;
            end else begin
                a  = (tab_area[r.idx] < jsfe_pkg::AREA_FLOOR) ? 128'(jsfe_pkg::AREA_FLOOR)
                                                              : 128'(tab_area[r.idx]);
                k  = (tab_stiff[r.idx] == 0) ? 128'd1 : 128'(tab_stiff[r.idx]);
                normal = div_capped(128'(r.lin) * jsfe_pkg::K_NORMAL, (128'(r.dt) * a) << 16,
                                    128'(jsfe_pkg::SAT48));
                // integer square root of the area in Q.8
                v = a << 16;
                root = '0;
                bitv = 128'd1 << 62;
                while (bitv > v) bitv = bitv >> 2;
                while (bitv != 0) begin
                    if (v >= root + bitv) begin
                        v = v - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                sx = a * root;
                if (sx < 128'(jsfe_pkg::SX_FLOOR)) sx = 128'(jsfe_pkg::SX_FLOOR);
                bending = div_capped(128'(r.ang) * jsfe_pkg::K_BEND_A * jsfe_pkg::K_BEND_B,
                                     (sx * 128'(r.dt)) << 8, 128'(jsfe_pkg::SAT48));
                stress = normal + bending;
                if (stress > 128'(jsfe_pkg::SAT48)) stress = 128'(jsfe_pkg::SAT48);
                strain = div_capped(stress << 32, k, 128'(jsfe_pkg::SAT32));
                e.stress = stress[47:0];
                e.strain = strain[31:0];
                if (stress[47:0] > step_max_stress) step_max_stress = stress[47:0];
                if (strain[31:0] > step_max_strain) step_max_strain = strain[31:0];
                if (stress > 128'(tab_yld[r.idx])) begin
                    yp  = (tab_yld[r.idx] == 0) ? 128'd1 : 128'(tab_yld[r.idx]);
                    inc = div_capped(((stress - yp) * 128'(r.dt) * 128'(model_rate)) << 8,
                                     yp * jsfe_pkg::K_USEC, 128'(jsfe_pkg::SAT32));
                    d = 128'(tab_dmg[r.idx]) + inc;
                    tab_dmg[r.idx] = (d > 128'(jsfe_pkg::SAT32)) ? jsfe_pkg::SAT32 : d[31:0];
                    tab_ymark[r.idx] = 1'b1;
                    e.yl = 1'b1;
                    if (step_yields < jsfe_pkg::CNT_MAX) step_yields++;
                end
                if (stress >= 128'(tab_tens[r.idx]) || tab_dmg[r.idx] >= 32'h0100_0000) begin
                    tab_bmark[r.idx] = 1'b1;
                    e.br  = 1'b1;
                    e.dis = 1'b1;
                    if (step_breaks < jsfe_pkg::CNT_MAX) step_breaks++;
                end
            end
        end
        e.ytot = step_yields;
        e.btot = step_breaks;
        e.pks  = step_max_stress;
        e.pkn  = step_max_strain;
        return e;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
        errors++;
    endtask

    // Compare each delivered result with the oldest prediction.
    always @(posedge i_clk) begin
        t_joint_res w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected_result", 64'd1, 64'd0);
            end else begin
                w = pending_results.pop_front();
                if (o_stress_pa != w.stress)
                    report_mismatch("stress_pa", o_stress_pa, w.stress);
                if (o_strain_frac != w.strain)
                    report_mismatch("strain_frac", o_strain_frac, w.strain);
                if (o_is_yielded != w.yl)
                    report_mismatch("is_yielded", o_is_yielded, w.yl);
                if (o_is_broken != w.br)
                    report_mismatch("is_broken", o_is_broken, w.br);
                if (o_disable_joint != w.dis)
                    report_mismatch("disable_joint", o_disable_joint, w.dis);
                if (o_yielded_total != w.ytot)
                    report_mismatch("yielded_total", o_yielded_total, w.ytot);
                if (o_broken_total != w.btot)
                    report_mismatch("broken_total", o_broken_total, w.btot);
                if (o_peak_stress != w.pks)
                    report_mismatch("peak_stress", o_peak_stress, w.pks);
                if (o_peak_strain != w.pkn)
                    report_mismatch("peak_strain", o_peak_strain, w.pkn);
            end
        end
    end

    // Result-side stall: random bursts, or one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 0;
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end
        end
    end

    // Offer one transaction, hold it until accepted, then predict it.
    task automatic send_item(t_joint_req r);
        i_in_valid        <= 1'b1;
        i_req_type        <= r.req;
        i_joint_index     <= r.idx;
        i_linear_impulse  <= r.lin;
        i_angular_impulse <= r.ang;
        i_time_step       <= r.dt;
        i_contact_area    <= r.area;
        i_stiffness       <= r.stiff;
        i_yield_limit     <= r.yld;
        i_tensile_limit   <= r.tens;
        do @(posedge i_clk); while (o_in_stall);
        pending_results = {pending_results, evaluate_joint(r)};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] rate);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_rate  = rate;
        @(posedge i_clk);
    endtask

    // Random value with a random count of leading zeros.
    function automatic logic [63:0] rand_mag(int width);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = v >> $urandom_range(0, 63);
        return v & ((64'd1 << width) - 1);
    endfunction

    function automatic t_joint_req make_item(int nearby);
        t_joint_req r;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)      r.req = jsfe_pkg::REQ_LOAD;
        else if (sel < 88) r.req = jsfe_pkg::REQ_EVAL;
        else if (sel < 96) r.req = jsfe_pkg::REQ_STEP;
        else               r.req = REQ_UNUSED;
        r.idx   = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, nearby - 1))
                                             : 10'($urandom_range(0, 1023));
        r.lin   = rand_mag(40);
        r.ang   = rand_mag(40);
        r.dt    = ($urandom_range(0, 19) == 0) ? 20'd0 : 20'($urandom_range(1, 1000000));
        r.area  = rand_mag(40);
        r.stiff = rand_mag(48);
        r.yld   = rand_mag(48);
        r.tens  = rand_mag(48);
        return r;
    endfunction

    function automatic t_joint_req make_req(logic [1:0] req, logic [9:0] idx, logic [39:0] lin,
                                            logic [39:0] ang, logic [19:0] dt);
        t_joint_req r;
        r = '{req: req, idx: idx, lin: lin, ang: ang, dt: dt,
              area: '0, stiff: '0, yld: '0, tens: '0};
        return r;
    endfunction

    // Extremes of the fields and each special case, under the reset damage rate.
    task automatic test_directed();
        t_joint_req r;
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd5, 40'd1000, 40'd1000, 20'd100)); // never loaded
        r = make_req(jsfe_pkg::REQ_LOAD, 10'd0, '0, '0, '0);
        r.area = '1; r.stiff = '1; r.yld = '1; r.tens = '1;
        send_item(r);
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd0, 40'd0, 40'd0, 20'd1000000));
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd0, '1, '1, 20'd1));            // saturation
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd0, 40'd65536, 40'd0, 20'd1000));
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd0, 40'd123456, 40'd0, 20'd0)); // zero step
        r = make_req(jsfe_pkg::REQ_LOAD, 10'd1, '0, '0, '0);                       // all floors
        send_item(r);
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1, 40'd1, 40'd1, 20'd1000000));
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1, 40'd1, 40'd1, 20'd1000000)); // broken
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1, 40'd1, 40'd1, 20'd0));
        r = make_req(jsfe_pkg::REQ_LOAD, 10'd1023, '0, '0, '0);                    // damage only
        r.area = 40'd1000000; r.stiff = 48'd1000000000; r.yld = 48'd1000; r.tens = '1;
        send_item(r);
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1023, 40'd65536, 40'd65536, 20'd16000));
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1023, 40'd65536, 40'd65536, 20'd16000));
        send_item(make_req(REQ_UNUSED, 10'd1023, '1, '1, '1));                     // unknown
        send_item(make_req(jsfe_pkg::REQ_STEP, 10'd0, '0, '0, '0));
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1023, 40'd65536, '1, 20'd1));
        r = make_req(jsfe_pkg::REQ_LOAD, 10'd0, '0, '0, '0);                       // reload
        r.area = 40'd9999; r.stiff = 48'd1; r.yld = 48'd0; r.tens = '1;
        send_item(r);
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd0, 40'd1, 40'd0, 20'd1000000));
        send_item(make_req(jsfe_pkg::REQ_EVAL, 10'd1, 40'd1, 40'd1, 20'd1));
    endtask

    task automatic test_random(int count, int nearby);
        repeat (count) send_item(make_item(nearby));
    endtask

    // Long receiver hold-off while the sender keeps offering.
    task automatic test_back_pressure();
        long_hold = 1;
        test_random(20, 8);
    endtask

    initial begin
        step_yields = '0;
        step_breaks = '0;
        step_max_stress = '0;
        step_max_strain = '0;
        model_rate = jsfe_pkg::DMG_RATE_RST;
        foreach (tab_valid[i]) tab_valid[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(250, 16);
        write_rate(16'd0);
        test_random(150, 16);
        write_rate(16'hFFFF);
        test_random(200, 16);
        test_back_pressure();
        write_rate(16'($urandom));
        test_random(300, 24);
        write_rate(jsfe_pkg::DMG_RATE_RST);
        quiet = 1;
        test_random(210, 16);
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/jsfe_pkg.sv
hw/rtl/jsfe_mul.sv
hw/rtl/jsfe_div.sv
hw/rtl/joint_stress_fracture_evaluator_top.sv
tb/sv/joint_stress_fracture_evaluator_top_test.sv
